// ===== hw/rtl/mbdlp_pkg.sv =====
`default_nettype none
package mbdlp_pkg;

	localparam int unsigned NumButtonsDef = 12;
	localparam int unsigned RawWidth      = 12;
	localparam int unsigned CountWidth    = 10;
	localparam int unsigned BtnCntWidth   = 4;
	localparam int unsigned CfgIdxWidth   = 2;
	localparam int unsigned CfgDataWidth  = 10;

	localparam logic [CountWidth-1:0] PressThrRst = 10'd32;
	localparam logic [CountWidth-1:0] LongThrRst  = 10'd1000;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_BUTTON_COUNT = 2'd0,
		REG_PRESS_THR    = 2'd1,
		REG_LONG_THR     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_LONG = 2'd2
	} mode_t;

	typedef struct packed {
		logic [BtnCntWidth-1:0] button_count;
		logic [CountWidth-1:0]  press_thr;
		logic [CountWidth-1:0]  long_thr;
	} cfg_t;

	typedef struct packed {
		logic is_on;
		logic is_held;
	} lane_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mbdlp_lane.sv =====
`default_nettype none
module mbdlp_lane #(
	parameter int unsigned LANE_IDX = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic                pressed,
	input  wire mbdlp_pkg::cfg_t     cfg,
	output mbdlp_pkg::lane_stat_t    stat
);

	localparam int unsigned CW = mbdlp_pkg::CountWidth;

	mbdlp_pkg::mode_t mode_q, mode_d;
	logic [CW-1:0]    count_q, count_d;
	logic             active;
	logic [CW:0]      count_inc;

	assign active    = (5'(LANE_IDX) < {1'b0, cfg.button_count});
	assign count_inc = {1'b0, count_q} + {{CW{1'b0}}, 1'b1};

	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		if (!active) begin
			mode_d  = mbdlp_pkg::MODE_OFF;
			count_d = '0;
		end else begin
			unique case (mode_q)
				mbdlp_pkg::MODE_OFF: begin
					if (pressed) begin
						if (count_inc >= {1'b0, cfg.press_thr}) begin
							mode_d  = mbdlp_pkg::MODE_ON;
							count_d = cfg.press_thr;
						end else begin
							count_d = count_inc[CW-1:0];
						end
					end else begin
						count_d = '0;
					end
				end
				mbdlp_pkg::MODE_ON: begin
					if (pressed) begin
						if (count_inc >= {1'b0, cfg.long_thr}) begin
							mode_d  = mbdlp_pkg::MODE_LONG;
							count_d = cfg.long_thr;
						end else begin
							count_d = count_inc[CW-1:0];
						end
					end else if (count_q <= CW'(1)) begin
						mode_d  = mbdlp_pkg::MODE_OFF;
						count_d = '0;
					end else begin
						count_d = count_q - CW'(1);
					end
				end
				default: begin
					if (pressed) begin
						count_d = cfg.press_thr;
					end else if (count_q <= CW'(1)) begin
						mode_d  = mbdlp_pkg::MODE_OFF;
						count_d = '0;
					end else begin
						count_d = count_q - CW'(1);
					end
				end
			endcase
		end
	end

	always_comb begin
		stat.is_on   = (mode_d == mbdlp_pkg::MODE_ON);
		stat.is_held = (mode_d != mbdlp_pkg::MODE_ON) && (mode_d != mbdlp_pkg::MODE_OFF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= mbdlp_pkg::MODE_OFF;
			count_q <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mbdlp_merge.sv =====
`default_nettype none
module mbdlp_merge #(
	parameter int unsigned NUM_BUTTONS = mbdlp_pkg::NumButtonsDef
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   load,
	input  wire mbdlp_pkg::lane_stat_t [NUM_BUTTONS-1:0] lane_stat,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic                                        free,
	output logic [mbdlp_pkg::RawWidth-1:0]              on_mask,
	output logic [mbdlp_pkg::RawWidth-1:0]              long_mask
);

	localparam int unsigned RW = mbdlp_pkg::RawWidth;

	logic [RW-1:0] on_d, long_d;
	logic [RW-1:0] on_mask_q, long_mask_q;
	logic          out_valid_q;

	for (genvar b = 0; b < RW; b++) begin : g_bit
		if (b < NUM_BUTTONS) begin : g_lane
			assign on_d[b]   = lane_stat[b].is_on;
			assign long_d[b] = lane_stat[b].is_held;
		end else begin : g_none
			assign on_d[b]   = 1'b0;
			assign long_d[b] = 1'b0;
		end
	end

	assign free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			on_mask_q   <= on_d;
			long_mask_q <= long_d;
		end
	end

	assign out_valid = out_valid_q;
	assign on_mask   = on_mask_q;
	assign long_mask = long_mask_q;

endmodule
`default_nettype wire

// ===== hw/rtl/multi_button_debounce_long_press.sv =====
// An input transfer's result is registered and shows on the output the next cycle.
// Throughput: one tick per cycle while no result is pending or out_ready is high;
// all button lanes update together on a tick, loading the output register anew.
// Reset: every lane off with count 0, no result pending, button_count 0,
// press_threshold 32, long_threshold 1000.
`default_nettype none
module multi_button_debounce_long_press #(
	parameter int unsigned NUM_BUTTONS = mbdlp_pkg::NumButtonsDef
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [mbdlp_pkg::RawWidth-1:0]       raw_levels,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [mbdlp_pkg::RawWidth-1:0]            on_mask,
	output logic [mbdlp_pkg::RawWidth-1:0]            long_mask,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mbdlp_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  wire logic [mbdlp_pkg::CfgDataWidth-1:0]   cfg_data
);

	mbdlp_pkg::cfg_t                        cfg_q;
	mbdlp_pkg::lane_stat_t [NUM_BUTTONS-1:0] lane_stat;
	logic                                   step;
	logic                                   free;

	assign cfg_ready = 1'b1;
	assign in_ready  = free;
	assign step      = in_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_count <= '0;
			cfg_q.press_thr    <= mbdlp_pkg::PressThrRst;
			cfg_q.long_thr     <= mbdlp_pkg::LongThrRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mbdlp_pkg::REG_BUTTON_COUNT:
					cfg_q.button_count <= cfg_data[mbdlp_pkg::BtnCntWidth-1:0];
				mbdlp_pkg::REG_PRESS_THR: cfg_q.press_thr <= cfg_data;
				mbdlp_pkg::REG_LONG_THR:  cfg_q.long_thr  <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic pressed;
		if (i < mbdlp_pkg::RawWidth) begin : g_pin
			assign pressed = !raw_levels[i];
		end else begin : g_nopin
			assign pressed = 1'b0;
		end
		mbdlp_lane #(
			.LANE_IDX (i)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.pressed (pressed),
			.cfg     (cfg_q),
			.stat    (lane_stat[i])
		);
	end

	mbdlp_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.lane_stat (lane_stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.on_mask   (on_mask),
		.long_mask (long_mask)
	);

endmodule
`default_nettype wire
